>>> hdl/dfb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfb_pkg: shared types and constants of the display frame builder
// Holds the transfer payload structs, the frame byte constants and the
// CRC-16/MODBUS byte update.
// ----------------------------------------------------------------------------
package dfb_pkg;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data_byte;
		logic [7:0]  payload_length;
		logic [15:0] vp_addr;
		logic [7:0]  word_count;
	} dfb_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_end;
		logic       run_last;
		logic       error;
	} dfb_out_t;

	// Item kinds.
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	// Frame bytes.
	localparam logic [7:0] HDR_HI    = 8'h5A;
	localparam logic [7:0] HDR_LO    = 8'hA5;
	localparam logic [7:0] CMD_WRITE = 8'h10;
	localparam logic [7:0] CMD_READ  = 8'h03;
	localparam logic [7:0] LEN_READ  = 8'h07;
	localparam logic [7:0] LEN_EXTRA = 8'h03;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// Largest number of bytes one item can cause, and the counter width.
	localparam int RES_MAX = 10;
	localparam int CNT_W   = 4;

	// One byte of CRC-16/MODBUS, least significant bit first.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	// CRC after the command byte alone, for each frame type.
	localparam logic [15:0] CRC_AFTER_WRITE = crc16_byte(CRC_INIT, CMD_WRITE);
	localparam logic [15:0] CRC_AFTER_READ  = crc16_byte(CRC_INIT, CMD_READ);

endpackage
`default_nettype wire

>>> hdl/display_frame_builder_crc16.sv
`timescale 1ns / 1ps
`default_nettype none
// Flow: an accepted item is registered in the input stage, then loaded into the result
// buffer, whose entry 0 is on the output; a busy buffer holds it in the input stage.
// Throughput: one item per cycle while each item causes a single byte and the
// receiver takes every byte; a longer item holds the output while the next one waits.
// Reset: arst_n clears asynchronously; no frame is open, the CRC returns to FFFF
// and both the input stage and the result buffer are emptied.
// ----------------------------------------------------------------------------
// display_frame_builder_crc16: serial command frame builder
// Turns write payload bytes and read requests into framed byte streams with
// header, length, command and a CRC-16/MODBUS trailer.
// ----------------------------------------------------------------------------
module display_frame_builder_crc16 #(
	parameter int MAX_PAYLOAD = 252
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire dfb_pkg::dfb_in_t  in_item,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output dfb_pkg::dfb_out_t      out_item
);
	import dfb_pkg::*;

	// Input stage. The item is registered here so that the frame logic below
	// sits between two registers.
	logic    valid_s1;
	dfb_in_t item_s1;

	// Frame state, updated when an item moves from the input stage into the
	// result buffer, so it always reflects every item handed on so far.
	logic        frame_open_q;
	logic [7:0]  bytes_left_q;
	logic [15:0] crc_q;

	// Result buffer: a short shift line of bytes; entry 0 is on the output.
	logic [7:0]         byte_q [RES_MAX];
	logic [RES_MAX-1:0] fend_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               err_q;

	// Bytes and state that the item in the input stage produces.
	logic [7:0]         res_byte [RES_MAX];
	logic [RES_MAX-1:0] res_fend;
	logic [CNT_W-1:0]   res_cnt;
	logic               res_err;
	logic               nxt_open;
	logic [7:0]         nxt_left;
	logic [15:0]        nxt_crc;
	logic [15:0]        crc_data;
	logic [15:0]        crc_rd;
	logic               in_xfer;
	logic               out_xfer;
	logic               load;

	assign out_xfer = out_valid && out_ready;
	assign in_xfer  = in_valid && in_ready;

	// The buffer is refilled when it is empty or its final byte leaves in this
	// cycle, so single-byte items flow at one per cycle while out_ready stays high.
	assign load     = valid_s1 && ((cnt_q == '0) || ((cnt_q == CNT_W'(1)) && out_ready));
	assign in_ready = !valid_s1 || load;

	// Read frame CRC: the command byte is folded in as a constant, then the
	// address high byte, address low byte, the zero byte and the word count.
	assign crc_rd = crc16_byte(crc16_byte(crc16_byte(crc16_byte(CRC_AFTER_READ,
		item_s1.vp_addr[15:8]), item_s1.vp_addr[7:0]), 8'h00),
		item_s1.word_count);

	// CRC after the payload byte: a new frame starts from the command CRC.
	assign crc_data = crc16_byte(frame_open_q ? crc_q : CRC_AFTER_WRITE, item_s1.data_byte);

	always_comb begin
		for (int i = 0; i < RES_MAX; i++) begin
			res_byte[i] = 8'h00;
		end
		res_fend = '0;
		res_cnt  = CNT_W'(1);
		res_err  = 1'b0;
		nxt_open = frame_open_q;
		nxt_left = bytes_left_q;
		nxt_crc  = crc_q;
		if (item_s1.kind == KIND_READ) begin
			if (frame_open_q) begin
				// A read cannot break into an open write frame.
				res_err = 1'b1;
			end else begin
				res_byte[0] = HDR_HI;
				res_byte[1] = HDR_LO;
				res_byte[2] = LEN_READ;
				res_byte[3] = CMD_READ;
				res_byte[4] = item_s1.vp_addr[15:8];
				res_byte[5] = item_s1.vp_addr[7:0];
				res_byte[6] = 8'h00;
				res_byte[7] = item_s1.word_count;
				res_byte[8] = crc_rd[7:0];
				res_byte[9] = crc_rd[15:8];
				res_fend[9] = 1'b1;
				res_cnt     = CNT_W'(10);
				nxt_open    = 1'b0;
				nxt_left    = 8'h00;
				nxt_crc     = CRC_INIT;
			end
		end else if (frame_open_q) begin
			// Continuing payload byte, with the trailer when it is the last.
			res_byte[0] = item_s1.data_byte;
			if (bytes_left_q <= 8'd1) begin
				res_byte[1] = crc_data[7:0];
				res_byte[2] = crc_data[15:8];
				res_fend[2] = 1'b1;
				res_cnt     = CNT_W'(3);
				nxt_open    = 1'b0;
				nxt_left    = 8'h00;
				nxt_crc     = CRC_INIT;
			end else begin
				nxt_left = bytes_left_q - 8'd1;
				nxt_crc  = crc_data;
			end
		end else if (item_s1.payload_length > 8'(MAX_PAYLOAD)) begin
			// Over-long frame: rejected, state left as it is.
			res_err = 1'b1;
		end else begin
			res_byte[0] = HDR_HI;
			res_byte[1] = HDR_LO;
			res_byte[2] = item_s1.payload_length + LEN_EXTRA;
			res_byte[3] = CMD_WRITE;
			if (item_s1.payload_length == 8'd0) begin
				// Empty frame: the CRC covers the command byte alone.
				res_byte[4] = CRC_AFTER_WRITE[7:0];
				res_byte[5] = CRC_AFTER_WRITE[15:8];
				res_fend[5] = 1'b1;
				res_cnt     = CNT_W'(6);
			end else begin
				res_byte[4] = item_s1.data_byte;
				if (item_s1.payload_length == 8'd1) begin
					res_byte[5] = crc_data[7:0];
					res_byte[6] = crc_data[15:8];
					res_fend[6] = 1'b1;
					res_cnt     = CNT_W'(7);
				end else begin
					res_cnt  = CNT_W'(5);
					nxt_open = 1'b1;
					nxt_left = item_s1.payload_length - 8'd1;
					nxt_crc  = crc_data;
				end
			end
		end
	end

	// Input stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1 <= in_item;
		end
	end

	// Frame state and buffer occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
			bytes_left_q <= 8'h00;
			crc_q        <= CRC_INIT;
			cnt_q        <= '0;
		end else if (load) begin
			frame_open_q <= nxt_open;
			bytes_left_q <= nxt_left;
			crc_q        <= nxt_crc;
			cnt_q        <= res_cnt;
		end else if (out_xfer) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// Buffer contents: loaded whole, then shifted by one on each transfer.
	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < RES_MAX; i++) begin
				byte_q[i] <= res_byte[i];
			end
			fend_q <= res_fend;
			err_q  <= res_err;
		end else if (out_xfer) begin
			for (int i = 0; i < RES_MAX - 1; i++) begin
				byte_q[i] <= byte_q[i+1];
			end
			fend_q <= fend_q >> 1;
		end
	end

	assign out_valid          = (cnt_q != '0);
	assign out_item.out_byte  = byte_q[0];
	assign out_item.frame_end = fend_q[0];
	assign out_item.run_last  = (cnt_q == CNT_W'(1));
	assign out_item.error     = err_q;

endmodule
`default_nettype wire

>>> hdl/dfb_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfb_checker: port-level checks of the display frame builder
// Watches the output channel and the shape of the byte stream.
// ----------------------------------------------------------------------------
module dfb_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire dfb_pkg::dfb_out_t out_item
);

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("output changed while stalled");

	// A rejected item gives a single, empty result.
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.error |->
		out_item.run_last && !out_item.frame_end && (out_item.out_byte == 8'h00))
		else $error("malformed error result");

	// The end of a frame is always the last byte of its item.
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.frame_end |-> out_item.run_last)
		else $error("frame end before last byte of item");

	// The bytes of one item follow without a gap.
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_item.run_last |=> out_valid)
		else $error("gap inside the bytes of one item");

endmodule

bind display_frame_builder_crc16 dfb_checker u_dfb_checker (.*);
`default_nettype wire

>>> tb/frame_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_check_pkg: expected byte streams of the display frame builder
// A scoreboard that rebuilds every frame byte, with its own CRC-16/MODBUS,
// from each accepted input transfer and compares the output transfers with it.
// ----------------------------------------------------------------------------
package frame_check_pkg;

	import dfb_pkg::*;

	localparam int unsigned MAX_PAYLOAD = 252;

	class frame_scoreboard;

		bit          frame_open  = 1'b0;
		bit [7:0]    bytes_left  = 8'd0;
		bit [15:0]   running_crc = CRC_INIT;
		dfb_out_t    frame_bytes[$];
		int unsigned mismatches  = 0;

		// Bit-serial form of the reflected CRC: feedback is the low CRC bit
		// against the incoming data bit.
		static function bit [15:0] modbus_crc_step(bit [15:0] crc, bit [7:0] b);
			bit fb;
			for (int i = 0; i < 8; i++) begin
				fb  = crc[0] ^ b[i];
				crc = crc >> 1;
				if (fb) begin
					crc = crc ^ CRC_POLY;
				end
			end
			return crc;
		endfunction

		function void add_byte(bit [7:0] value, bit last_of_frame, bit err);
			dfb_out_t r;
			r.out_byte  = value;
			r.frame_end = last_of_frame;
			r.run_last  = 1'b0;
			r.error     = err;
			frame_bytes.push_back(r);
		endfunction

		// The trailer goes out low byte first; its high byte ends the frame.
		function void add_crc(bit [15:0] crc);
			add_byte(crc[7:0], 1'b0, 1'b0);
			add_byte(crc[15:8], 1'b1, 1'b0);
		endfunction

		function void close_frame();
			frame_open  = 1'b0;
			bytes_left  = 8'd0;
			running_crc = CRC_INIT;
		endfunction

		function void add_header(bit [7:0] len, bit [7:0] cmd);
			add_byte(HDR_HI, 1'b0, 1'b0);
			add_byte(HDR_LO, 1'b0, 1'b0);
			add_byte(len, 1'b0, 1'b0);
			add_byte(cmd, 1'b0, 1'b0);
		endfunction

		function void note_item(dfb_in_t it);
			bit [7:0]  req_body[4];
			bit [15:0] req_crc;
			if (it.kind == KIND_READ) begin
				if (frame_open) begin
					add_byte(8'h00, 1'b0, 1'b1);
				end else begin
					// The read length travels as a word: a zero high byte first.
					req_body = '{it.vp_addr[15:8], it.vp_addr[7:0], 8'h00,
						it.word_count};
					add_header(LEN_READ, CMD_READ);
					req_crc = modbus_crc_step(CRC_INIT, CMD_READ);
					foreach (req_body[i]) begin
						add_byte(req_body[i], 1'b0, 1'b0);
						req_crc = modbus_crc_step(req_crc, req_body[i]);
					end
					add_crc(req_crc);
					close_frame();
				end
			end else if (!frame_open && it.payload_length > MAX_PAYLOAD) begin
				add_byte(8'h00, 1'b0, 1'b1);
			end else begin
				if (!frame_open) begin
					add_header(it.payload_length + LEN_EXTRA, CMD_WRITE);
					running_crc = modbus_crc_step(CRC_INIT, CMD_WRITE);
					if (it.payload_length == 8'd0) begin
						add_crc(running_crc);
						close_frame();
					end else begin
						frame_open = 1'b1;
						bytes_left = it.payload_length;
					end
				end
				if (frame_open) begin
					add_byte(it.data_byte, 1'b0, 1'b0);
					running_crc = modbus_crc_step(running_crc, it.data_byte);
					if (bytes_left <= 8'd1) begin
						add_crc(running_crc);
						close_frame();
					end else begin
						bytes_left = bytes_left - 8'd1;
					end
				end
			end
			frame_bytes[frame_bytes.size() - 1].run_last = 1'b1;
		endfunction

		function void check_byte(dfb_out_t got);
			dfb_out_t want;
			if (frame_bytes.size() == 0) begin
				$error("out_byte %02h arrived with nothing outstanding", got.out_byte);
				mismatches++;
				return;
			end
			want = frame_bytes.pop_front();
			if (got.out_byte !== want.out_byte) begin
				$error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
				mismatches++;
			end
			if (got.frame_end !== want.frame_end) begin
				$error("frame_end: expected %b, got %b", want.frame_end, got.frame_end);
				mismatches++;
			end
			if (got.run_last !== want.run_last) begin
				$error("run_last: expected %b, got %b", want.run_last, got.run_last);
				mismatches++;
			end
			if (got.error !== want.error) begin
				$error("error: expected %b, got %b", want.error, got.error);
				mismatches++;
			end
		endfunction

		function int unsigned outstanding();
			return frame_bytes.size();
		endfunction

	endclass

endpackage

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for display_frame_builder_crc16
// Drives write payload bytes and read requests through the input channel,
// rebuilds every frame byte in a scoreboard and compares each output transfer
// with it, under several patterns of sender gaps and receiver back-pressure.
// ----------------------------------------------------------------------------
module tb;

	import dfb_pkg::*;
	import frame_check_pkg::*;

	// Longest run of cycles without any transfer before the bench gives up.
	// The worst honest run is a long receiver stall.
	localparam int unsigned QUIET_LIMIT  = 2000;
	// The settle time leaves ample room for stray bytes to show up.
	localparam int unsigned SETTLE_TICKS = 20;
	localparam int unsigned PHASE_ITEMS  = 55;

	// Sender idle and receiver stall percentages for each phase.
	localparam int IDLE_PCT[4]  = '{0, 62, 0, 9};
	localparam int STALL_PCT[4] = '{0, 0, 62, 9};

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     in_valid  = 1'b0;
	logic     in_ready;
	dfb_in_t  in_item   = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	dfb_out_t out_item;

	int          idle_pct     = 0;
	int          stall_pct    = 0;
	int unsigned items_sent   = 0;
	int unsigned quiet_cycles = 0;

	frame_scoreboard frames;

	display_frame_builder_crc16 u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// 12 ns clock period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// The receiver decides afresh on every edge whether it will take a byte,
	// so stalls land on header, payload and CRC bytes alike.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Output monitor and watchdog. Both read values from before the edge, so
	// the outcome does not depend on the order of processes within the step.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			frames.check_byte(out_item);
		end
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		@(posedge clk);
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
		end
		$display("tb NOT OK");
		$finish;
	end

	// Offers one item and returns at the edge where its transfer takes place.
	// The item is handed to the scoreboard here rather than in the monitor, so
	// that the stimulus can rely on the frame state straight afterwards.
	task automatic send_item(dfb_in_t it);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		do begin
			@(posedge clk);
		end while (!in_ready);
		frames.note_item(it);
		items_sent++;
	endtask

	task automatic send_fields(logic kind, logic [7:0] data, logic [7:0] plen,
		logic [15:0] addr, logic [7:0] rlen);
		dfb_in_t it;
		it.kind           = kind;
		it.data_byte      = data;
		it.payload_length = plen;
		it.vp_addr        = addr;
		it.word_count     = rlen;
		send_item(it);
	endtask

	function automatic dfb_in_t any_item(logic kind);
		dfb_in_t it;
		it.kind           = kind;
		it.data_byte      = 8'($urandom);
		it.payload_length = 8'($urandom);
		it.vp_addr        = 16'($urandom);
		it.word_count     = 8'($urandom);
		return it;
	endfunction

	// Mostly short frames; empty ones now and then, a few longer ones.
	function automatic int unsigned pick_length();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 8) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(6, 1);
		end else if (r < 97) begin
			return $urandom_range(32, 7);
		end else begin
			return $urandom_range(64, 33);
		end
	endfunction

	// A well-formed write frame with random content. Later items carry random
	// lengths, which must be ignored, and now and then a read request that has
	// to be refused while the frame is open.
	task automatic send_write_frame(int unsigned len);
		dfb_in_t it;
		it = any_item(KIND_WRITE);
		it.payload_length = 8'(len);
		send_item(it);
		while (frames.frame_open) begin
			if ($urandom_range(99) < 8) begin
				send_item(any_item(KIND_READ));
			end else begin
				send_item(any_item(KIND_WRITE));
			end
		end
	endtask

	task automatic send_random_mix();
		dfb_in_t     it;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 55) begin
			send_write_frame(pick_length());
		end else if (pick < 75) begin
			send_item(any_item(KIND_READ));
		end else if (pick < 85) begin
			it = any_item(KIND_WRITE);
			it.payload_length = 8'($urandom_range(255, MAX_PAYLOAD + 1));
			send_item(it);
		end else begin
			// Loose item: may open a short frame and leave it open, so that
			// whatever comes next lands in the middle of it.
			it = any_item(1'($urandom_range(1)));
			if (it.kind == KIND_WRITE) begin
				it.payload_length = ($urandom_range(3) != 0) ? 8'($urandom_range(6))
					: 8'($urandom_range(255, MAX_PAYLOAD + 1));
			end
			send_item(it);
		end
	endtask

	// The sender holds off until every byte owed so far has been taken.
	task automatic drain_frames();
		in_valid <= 1'b0;
		@(posedge clk);
		while (frames.outstanding() != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin
		int unsigned phase_end;
		frames = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: empty frame, length limit, read extremes, one-byte
		// frames, and short frames interrupted by refused reads whose later
		// items carry lengths that must be ignored.
		send_fields(KIND_WRITE, 8'hFF, 8'd0, 16'hFFFF, 8'hFF);
		send_fields(KIND_WRITE, 8'h00, 8'd253, 16'h0000, 8'h00);
		send_fields(KIND_WRITE, 8'hFF, 8'd255, 16'hFFFF, 8'hFF);
		send_fields(KIND_READ, 8'h00, 8'h00, 16'h0000, 8'h00);
		send_fields(KIND_READ, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
		send_fields(KIND_READ, 8'h5A, 8'd4, 16'h00FF, 8'h01);
		send_fields(KIND_WRITE, 8'h00, 8'd1, 16'h0000, 8'h00);
		send_fields(KIND_WRITE, 8'hFF, 8'd1, 16'hFFFF, 8'hFF);
		send_fields(KIND_WRITE, 8'h5A, 8'd3, 16'h1234, 8'h10);
		send_fields(KIND_READ, 8'h00, 8'h00, 16'hFF00, 8'h80);
		send_fields(KIND_WRITE, 8'hA5, 8'hFF, 16'hFFFF, 8'hFF);
		send_fields(KIND_READ, 8'hFF, 8'h00, 16'h0000, 8'h7F);
		send_fields(KIND_WRITE, 8'h00, 8'd0, 16'h0000, 8'h00);
		send_fields(KIND_WRITE, 8'h80, 8'd2, 16'hA5A5, 8'h55);
		send_fields(KIND_WRITE, 8'h01, 8'd253, 16'h5A5A, 8'hAA);
		send_fields(KIND_WRITE, 8'h10, 8'd3, 16'h0000, 8'h00);
		send_fields(KIND_WRITE, 8'h00, 8'd200, 16'h0000, 8'h00);
		send_fields(KIND_WRITE, 8'h00, 8'd0, 16'h0000, 8'h00);
		drain_frames();

		// Random part, one phase per idling pattern.
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct  = IDLE_PCT[ph];
			stall_pct = STALL_PCT[ph];
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				send_random_mix();
			end
			drain_frames();
		end

		repeat (SETTLE_TICKS) @(posedge clk);
		if (frames.outstanding() != 0) begin
			$error("%0d frame bytes never arrived", frames.outstanding());
			frames.mismatches++;
		end
		if (frames.mismatches == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
